// ===== rtl/ctt_pkg.sv =====
// Shared types and constants of the channel translocation tracker.
`timescale 1ns / 1ps

package ctt_pkg;

	// Field widths.
	localparam int Z_W     = 24;
	localparam int LEN_W   = 23;
	localparam int PART_W  = 10;
	localparam int CNT_W   = 32;
	localparam int SUM_W   = 48;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 2;

	// The remainder unit retires one dividend bit per stage.
	localparam int DIV_STEPS = Z_W;

	// Queue depths.
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam int DEF_MAX_PARTICLES = 1024;

	// Register reset values.
	localparam logic [LEN_W-1:0] BOX_LENGTH_RST  = LEN_W'(655360);
	localparam logic [Z_W-1:0]   LOWER_BOUND_RST = '0;
	localparam logic [Z_W-1:0]   UPPER_BOUND_RST = '0;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND = 2'd2;

	typedef enum logic [1:0] {
		ZONE_BELOW  = 2'd0,
		ZONE_INSIDE = 2'd1,
		ZONE_ABOVE  = 2'd2
	} zone_t;

	// A classified transaction on its way from the front to the back.
	typedef struct packed {
		logic [Z_W-1:0]    wz;
		zone_t             zone;
		logic              strict;
		logic              rerr;
		logic [PART_W-1:0] particle;
		logic              last;
	} mid_t;

	// One result transaction.
	typedef struct packed {
		logic [Z_W-1:0]   wrapped_z;
		zone_t            zone;
		logic             event_res;
		logic             direction;
		logic [CNT_W-1:0] dwell_frames;
		logic [CNT_W-1:0] frame_index;
		logic [CNT_W-1:0] occupied_frames;
		logic [CNT_W-1:0] event_count;
		logic [SUM_W-1:0] dwell_total;
		logic             range_error;
	} res_t;

endpackage

// ===== rtl/ctt_fifo.sv =====
// Small synchronous FIFO used between the tracker's parts and at its output.
`timescale 1ns / 1ps

module ctt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         rd,
	output logic [WIDTH-1:0]             rdata,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;
	assign rdata = mem_q[rd_ptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ctt_front.sv =====
// Front part: periodic wrap through a pipelined remainder unit, range check and zone classification.
`timescale 1ns / 1ps

module ctt_front import ctt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic signed [Z_W-1:0]   z_pos,
	input  logic [PART_W-1:0]       particle,
	input  logic                    last_of_frame,
	input  logic [LEN_W-1:0]        box_length,
	input  logic signed [Z_W-1:0]   lower_bound,
	input  logic signed [Z_W-1:0]   upper_bound,
	input  logic                    mid_full,
	output logic                    adv,
	output logic                    mid_push,
	output mid_t                    mid_data
);

	typedef struct packed {
		logic [LEN_W-1:0]  rem;
		logic [Z_W-1:0]    mag;
		logic              neg;
		logic              rerr;
		logic [PART_W-1:0] particle;
		logic              last;
	} div_t;

	typedef struct packed {
		logic [LEN_W-1:0]  r;
		logic              rerr;
		logic [PART_W-1:0] particle;
		logic              last;
	} fix_t;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	function automatic div_t div_step(div_t d, logic [LEN_W-1:0] len);
		logic [LEN_W:0] t;
		div_t           o;
		o = d;
		t = {d.rem, d.mag[Z_W-1]};
		if (t >= {1'b0, len}) begin
			t = t - {1'b0, len};
		end
		o.rem = t[LEN_W-1:0];
		o.mag = {d.mag[Z_W-2:0], 1'b0};
		return o;
	endfunction

	logic [LEN_W-1:0]     len_eff;
	logic signed [Z_W+1:0] zx;
	logic signed [Z_W+1:0] len_x;
	logic signed [Z_W+1:0] len2_x;
	div_t                 div_in;
	div_t                 div_s    [DIV_STEPS+1];
	logic [DIV_STEPS:0]   div_vld_s;
	fix_t                 fix_in;
	fix_t                 fix_s;
	logic                 fix_vld_s;
	logic signed [Z_W:0]  w_c;
	logic signed [Z_W:0]  lo_c;
	logic signed [Z_W:0]  hi_c;
	logic signed [Z_W:0]  lom1_c;
	logic signed [Z_W:0]  hip1_c;
	logic                 below_c;
	logic                 above_c;

	// A zero box length behaves as a length of one.
	assign len_eff = (box_length == '0) ? LEN_W'(1) : box_length;

	// Entry: magnitude and sign for the remainder unit, range check on the raw value.
	always_comb begin
		zx     = {{2{z_pos[Z_W-1]}}, z_pos};
		len_x  = {3'b000, len_eff};
		len2_x = {2'b00, len_eff, 1'b0};
		div_in.rem      = '0;
		div_in.neg      = z_pos[Z_W-1];
		div_in.mag      = z_pos[Z_W-1] ? (~z_pos + Z_W'(1)) : z_pos;
		div_in.rerr     = (zx < -len_x) || (zx >= len2_x);
		div_in.particle = particle;
		div_in.last     = last_of_frame;
	end

	// Fold the magnitude remainder back into [0, len) for negative inputs.
	always_comb begin
		fix_in.r        = (div_s[DIV_STEPS].neg && div_s[DIV_STEPS].rem != '0) ?
		                  (len_eff - div_s[DIV_STEPS].rem) : div_s[DIV_STEPS].rem;
		fix_in.rerr     = div_s[DIV_STEPS].rerr;
		fix_in.particle = div_s[DIV_STEPS].particle;
		fix_in.last     = div_s[DIV_STEPS].last;
	end

	// The whole front moves together unless the middle queue cannot take the oldest transaction.
	assign adv      = !(mid_full && fix_vld_s);
	assign mid_push = fix_vld_s && !mid_full;

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s <= '0;
			fix_vld_s <= 1'b0;
		end else if (adv) begin
			div_vld_s <= {div_vld_s[DIV_STEPS-1:0], take};
			fix_vld_s <= div_vld_s[DIV_STEPS];
		end
	end

	// Payload of the pipeline.
	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= div_in;
			for (int k = 0; k < DIV_STEPS; k++) begin
				div_s[k+1] <= div_step(div_s[k], len_eff);
			end
			fix_s <= fix_in;
		end
	end

	// Classify against the channel and clamp one step past the nearer bound.
	always_comb begin
		w_c     = {2'b00, fix_s.r};
		lo_c    = {lower_bound[Z_W-1], lower_bound};
		hi_c    = {upper_bound[Z_W-1], upper_bound};
		lom1_c  = lo_c - (Z_W+1)'(1);
		hip1_c  = hi_c + (Z_W+1)'(1);
		below_c = (w_c < lo_c);
		above_c = !below_c && (w_c > hi_c);
		mid_data.strict   = (w_c > lo_c) && (w_c < hi_c);
		mid_data.rerr     = fix_s.rerr;
		mid_data.particle = fix_s.particle;
		mid_data.last     = fix_s.last;
		if (below_c) begin
			mid_data.wz   = lom1_c[Z_W-1:0];
			mid_data.zone = ZONE_BELOW;
		end else if (above_c) begin
			mid_data.wz   = hip1_c[Z_W-1:0];
			mid_data.zone = ZONE_ABOVE;
		end else begin
			mid_data.wz   = {1'b0, fix_s.r};
			mid_data.zone = ZONE_INSIDE;
		end
	end

endmodule

// ===== rtl/ctt_back.sv =====
// Back part: per-particle state memory, translocation detection and saturating counters.
`timescale 1ns / 1ps

module ctt_back import ctt_pkg::*; #(
	parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mid_empty,
	input  mid_t                 mid_head,
	output logic                 mid_pop,
	input  logic [OUT_CNT_W-1:0] out_count,
	output logic                 out_push,
	output res_t                 out_data,
	output logic                 clearing
);

	localparam int PIDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int PAD_W  = (PIDX_W > PART_W) ? PIDX_W : PART_W;

	typedef struct packed {
		zone_t            start;
		zone_t            prev;
		logic [CNT_W-1:0] outside;
	} pst_t;

	localparam pst_t PST_RST = '{start: ZONE_INSIDE, prev: ZONE_INSIDE, outside: '0};

	function automatic logic [PIDX_W-1:0] addr_of(logic [PART_W-1:0] p);
		logic [PAD_W-1:0] wide;
		wide = PAD_W'(p);
		return wide[PIDX_W-1:0];
	endfunction

	pst_t                 mem_q [MAX_PARTICLES];
	pst_t                 rd_q;
	logic                 byp_q;
	pst_t                 byp_data_q;
	logic                 clr_active_q;
	logic [PIDX_W-1:0]    clr_q;
	logic                 b1_vld_s;
	mid_t                 b1_s;
	logic                 b2_vld_s;
	res_t                 b2_s;
	logic [CNT_W-1:0]     frame_q;
	logic                 frame_occ_q;
	logic [CNT_W-1:0]     occ_total_q;
	logic [CNT_W-1:0]     event_total_q;
	logic [SUM_W-1:0]     dwell_sum_q;

	logic [OUT_CNT_W:0]   pending;
	logic                 room;
	logic                 in_range;
	logic [PIDX_W-1:0]    b1_addr;
	pst_t                 cur;
	pst_t                 nst;
	logic                 ev;
	logic                 dir;
	logic [CNT_W-1:0]     dwell;
	logic                 occ_now;
	logic [CNT_W-1:0]     occ_nxt;
	logic                 mem_we;
	logic [PIDX_W-1:0]    mem_waddr;
	pst_t                 mem_wdata;
	logic [CNT_W-1:0]     evt_nxt;
	logic [SUM_W:0]       dsum_add;
	logic [SUM_W-1:0]     dsum_nxt;

	assign clearing = clr_active_q;

	// Take from the middle queue only when the output queue has a slot for every transaction in flight.
	assign pending = {1'b0, out_count} + (OUT_CNT_W+1)'(b1_vld_s) + (OUT_CNT_W+1)'(b2_vld_s);
	assign room    = (pending < (OUT_CNT_W+1)'(OUT_DEPTH));
	assign mid_pop = !clr_active_q && !mid_empty && room;

	assign in_range = ({{(32-PART_W){1'b0}}, b1_s.particle} < 32'(MAX_PARTICLES));
	assign b1_addr  = addr_of(b1_s.particle);

	// Stage one: per-particle update from the state read at pop time.
	always_comb begin
		cur   = byp_q ? byp_data_q : rd_q;
		nst   = cur;
		ev    = 1'b0;
		dir   = 1'b0;
		dwell = '0;
		if (frame_q == '0) begin
			nst.start = b1_s.zone;
			nst.prev  = b1_s.zone;
		end else begin
			if (b1_s.zone != ZONE_INSIDE) begin
				if (cur.prev == ZONE_INSIDE && b1_s.zone != cur.start) begin
					ev    = 1'b1;
					dir   = (cur.start != ZONE_BELOW);
					dwell = frame_q - cur.outside;
				end
				nst.start   = b1_s.zone;
				nst.outside = frame_q;
			end
			nst.prev = b1_s.zone;
		end
		if (!in_range) begin
			ev    = 1'b0;
			dir   = 1'b0;
			dwell = '0;
		end
	end

	// Occupancy of the current frame, closed on its last transaction.
	assign occ_now = frame_occ_q || b1_s.strict;
	assign occ_nxt = (b1_s.last && occ_now && occ_total_q != '1) ? occ_total_q + 1'b1 :
	                 occ_total_q;

	// Memory write: the clearing pass after reset, then one update per in-range transaction.
	always_comb begin
		if (clr_active_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = PST_RST;
		end else begin
			mem_we    = b1_vld_s && in_range;
			mem_waddr = b1_addr;
			mem_wdata = nst;
		end
	end

	// State memory with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mid_pop) begin
			rd_q <= mem_q[addr_of(mid_head.particle)];
		end
	end

	// Forward the update of the previous transaction when it hits the same particle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (mid_pop) begin
			byp_q <= b1_vld_s && in_range && (b1_addr == addr_of(mid_head.particle));
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			byp_data_q <= nst;
		end
	end

	// Clearing pass over every entry after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_q        <= '0;
		end else if (clr_active_q) begin
			if (clr_q == PIDX_W'(MAX_PARTICLES - 1)) begin
				clr_active_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Stage valids and frame counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_vld_s    <= 1'b0;
			b2_vld_s    <= 1'b0;
			frame_q     <= '0;
			frame_occ_q <= 1'b0;
			occ_total_q <= '0;
		end else begin
			b1_vld_s <= mid_pop;
			b2_vld_s <= b1_vld_s;
			if (b1_vld_s) begin
				occ_total_q <= occ_nxt;
				if (b1_s.last) begin
					frame_occ_q <= 1'b0;
					if (frame_q != '1) begin
						frame_q <= frame_q + 1'b1;
					end
				end else begin
					frame_occ_q <= occ_now;
				end
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (mid_pop) begin
			b1_s <= mid_head;
		end
		if (b1_vld_s) begin
			b2_s.wrapped_z       <= b1_s.wz;
			b2_s.zone            <= b1_s.zone;
			b2_s.event_res       <= ev;
			b2_s.direction       <= dir;
			b2_s.dwell_frames    <= dwell;
			b2_s.frame_index     <= frame_q;
			b2_s.occupied_frames <= occ_nxt;
			b2_s.event_count     <= '0;
			b2_s.dwell_total     <= '0;
			b2_s.range_error     <= b1_s.rerr;
		end
	end

	// Stage two: event and dwell totals.
	assign evt_nxt  = (b2_s.event_res && event_total_q != '1) ? event_total_q + 1'b1 :
	                  event_total_q;
	assign dsum_add = {1'b0, dwell_sum_q} + (SUM_W+1)'(b2_s.dwell_frames);
	assign dsum_nxt = !b2_s.event_res ? dwell_sum_q :
	                  (dsum_add[SUM_W] ? '1 : dsum_add[SUM_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_total_q <= '0;
			dwell_sum_q   <= '0;
		end else if (b2_vld_s) begin
			event_total_q <= evt_nxt;
			dwell_sum_q   <= dsum_nxt;
		end
	end

	always_comb begin
		out_data             = b2_s;
		out_data.event_count = evt_nxt;
		out_data.dwell_total = dsum_nxt;
	end

	assign out_push = b2_vld_s;

endmodule

// ===== rtl/channel_translocation_tracker.sv =====
// Top level of the channel translocation tracker.
`timescale 1ns / 1ps

// The tracker takes one particle coordinate per clock and gives one result per
// coordinate, in order. A coordinate is accepted while full is low; results wait
// in a four-entry output queue and are taken with pop while empty is low. The
// periodic wrap goes through a 24-stage remainder unit that retires one dividend
// bit per stage, followed by a fold stage, a four-entry middle queue and two
// stages around the per-particle state memory. That memory is read and written
// once per transaction with forwarding between neighbors, so the sustained rate
// is one transaction per cycle while results are popped without stalls. After
// reset, full stays high while a clearing pass sets every particle entry to its
// reset state; configuration writes are taken during that pass.
module channel_translocation_tracker import ctt_pkg::*; #(
	parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    push,
	output logic                    full,
	input  logic signed [Z_W-1:0]   z_pos,
	input  logic [PART_W-1:0]       particle,
	input  logic                    last_of_frame,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [Z_W-1:0]   wrapped_z,
	output logic [1:0]              zone,
	output logic                    event_res,
	output logic                    direction,
	output logic [CNT_W-1:0]        dwell_frames,
	output logic [CNT_W-1:0]        frame_index,
	output logic [CNT_W-1:0]        occupied_frames,
	output logic [CNT_W-1:0]        event_count,
	output logic [SUM_W-1:0]        dwell_total,
	output logic                    range_error
);

	logic [LEN_W-1:0]      box_length_q;
	logic [Z_W-1:0]        lower_bound_q;
	logic [Z_W-1:0]        upper_bound_q;
	logic                  take;
	logic                  adv;
	logic                  mid_push;
	mid_t                  mid_wdata;
	mid_t                  mid_head;
	logic                  mid_full;
	logic                  mid_empty;
	logic                  mid_pop;
	logic                  out_push;
	res_t                  out_wdata;
	res_t                  out_head;
	logic                  out_full;
	logic [OUT_CNT_W-1:0]  out_count;
	logic                  clearing;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_length_q  <= BOX_LENGTH_RST;
			lower_bound_q <= LOWER_BOUND_RST;
			upper_bound_q <= UPPER_BOUND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOX_LENGTH:  box_length_q  <= cfg_wdata[LEN_W-1:0];
				CFG_LOWER_BOUND: lower_bound_q <= cfg_wdata[Z_W-1:0];
				CFG_UPPER_BOUND: upper_bound_q <= cfg_wdata[Z_W-1:0];
				default: ;
			endcase
		end
	end

	// Input handshake.
	assign full = clearing || !adv;
	assign take = push && !full;

	ctt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.z_pos         (z_pos),
		.particle      (particle),
		.last_of_frame (last_of_frame),
		.box_length    (box_length_q),
		.lower_bound   ($signed(lower_bound_q)),
		.upper_bound   ($signed(upper_bound_q)),
		.mid_full      (mid_full),
		.adv           (adv),
		.mid_push      (mid_push),
		.mid_data      (mid_wdata)
	);

	ctt_fifo #(
		.WIDTH ($bits(mid_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_push),
		.wdata  (mid_wdata),
		.rd     (mid_pop),
		.rdata  (mid_head),
		.full   (mid_full),
		.empty  (mid_empty),
		.count  ()
	);

	ctt_back #(
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_head  (mid_head),
		.mid_pop   (mid_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_data  (out_wdata),
		.clearing  (clearing)
	);

	ctt_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_push),
		.wdata  (out_wdata),
		.rd     (pop),
		.rdata  (out_head),
		.full   (out_full),
		.empty  (empty),
		.count  (out_count)
	);

	// Result fields.
	assign wrapped_z       = $signed(out_head.wrapped_z);
	assign zone            = out_head.zone;
	assign event_res       = out_head.event_res;
	assign direction       = out_head.direction;
	assign dwell_frames    = out_head.dwell_frames;
	assign frame_index     = out_head.frame_index;
	assign occupied_frames = out_head.occupied_frames;
	assign event_count     = out_head.event_count;
	assign dwell_total     = out_head.dwell_total;
	assign range_error     = out_head.range_error;

	// The front never pushes into a full middle queue.
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full)
		else $error("middle queue written while full");

	// The back's slot reservation keeps the output queue from overflowing.
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("output queue written while full");

	// No transaction reaches the state memory during the clearing pass.
	a_no_pop_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !mid_pop)
		else $error("transaction taken during clearing pass");

	// A translocation always leaves a nonzero event total behind it.
	a_event_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_wdata.event_res) |-> (out_wdata.event_count != '0))
		else $error("event without event count");

endmodule

// ===== sim/channel_translocation_tracker_tb.sv =====
// Self-checking testbench for the channel translocation tracker.
`timescale 1ns / 1ps

module channel_translocation_tracker_tb;
	import ctt_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PRINT_CAP = 100;

	// Keeps the block's predicted state and the results still owed by the block.
	class transit_scoreboard;
		logic [LEN_W-1:0]      box_len;
		logic signed [Z_W-1:0] lo_edge;
		logic signed [Z_W-1:0] hi_edge;
		zone_t                 entry_zone[DEF_MAX_PARTICLES];
		zone_t                 last_zone[DEF_MAX_PARTICLES];
		logic [CNT_W-1:0]      left_frame[DEF_MAX_PARTICLES];
		logic [CNT_W-1:0]      frame_no;
		logic                  frame_busy;
		logic [CNT_W-1:0]      busy_frames;
		logic [CNT_W-1:0]      crossings;
		logic [SUM_W-1:0]      dwell_sum;
		res_t                  results_due[$];
		int unsigned           errors;
		int unsigned           results_seen;

		function new();
			box_len = BOX_LENGTH_RST;
			lo_edge = LOWER_BOUND_RST;
			hi_edge = UPPER_BOUND_RST;
			foreach (entry_zone[i]) begin
				entry_zone[i] = ZONE_INSIDE;
				last_zone[i] = ZONE_INSIDE;
				left_frame[i] = '0;
			end
			frame_no = '0;
			frame_busy = 1'b0;
			busy_frames = '0;
			crossings = '0;
			dwell_sum = '0;
			errors = 0;
			results_seen = 0;
		endfunction

		// Mirrors a register write into the predicted configuration.
		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_BOX_LENGTH: box_len = data[LEN_W-1:0];
				CFG_LOWER_BOUND: lo_edge = data;
				CFG_UPPER_BOUND: hi_edge = data;
				default: ;
			endcase
		endfunction

		// Wraps, classifies and tracks one accepted coordinate transaction.
		function void note_coordinate(logic signed [Z_W-1:0] z, logic [PART_W-1:0] p,
				logic last);
			longint zl, len, lo, hi, w;
			zone_t zn;
			res_t e;
			logic [CNT_W-1:0] dwell;
			logic [SUM_W:0] sum;
			e = '0;
			len = (box_len == '0) ? 64'sd1 : longint'(box_len);
			zl = longint'(z);
			lo = longint'(lo_edge);
			hi = longint'(hi_edge);
			e.range_error = (zl < -len) || (zl >= 2 * len);

			// Exact periodic reduction into [0, len).
			w = zl % len;
			if (w < 0)
				w += len;

			// Outside values are clamped one step past the nearer edge.
			if (w < lo) begin
				w = lo - 1;
				zn = ZONE_BELOW;
			end else if (w > hi) begin
				w = hi + 1;
				zn = ZONE_ABOVE;
			end else begin
				zn = ZONE_INSIDE;
			end
			if (w > lo && w < hi)
				frame_busy = 1'b1;
			e.frame_index = frame_no;

			// Per-particle tracking: frame zero only records the starting zone.
			if (p < DEF_MAX_PARTICLES) begin
				if (frame_no == '0) begin
					entry_zone[p] = zn;
					last_zone[p] = zn;
				end else begin
					if (zn != ZONE_INSIDE) begin
						if (last_zone[p] == ZONE_INSIDE && zn != entry_zone[p]) begin
							dwell = frame_no - left_frame[p];
							e.event_res = 1'b1;
							e.direction = (entry_zone[p] == ZONE_BELOW) ? 1'b0 : 1'b1;
							e.dwell_frames = dwell;
							if (crossings != '1)
								crossings++;
							sum = dwell_sum + dwell;
							dwell_sum = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
						end
						entry_zone[p] = zn;
						left_frame[p] = frame_no;
					end
					last_zone[p] = zn;
				end
			end

			// Frame close: occupancy and the frame number move on.
			if (last) begin
				if (frame_busy && busy_frames != '1)
					busy_frames++;
				frame_busy = 1'b0;
				if (frame_no != '1)
					frame_no++;
			end

			e.wrapped_z = Z_W'(w);
			e.zone = zn;
			e.occupied_frames = busy_frames;
			e.event_count = crossings;
			e.dwell_total = dwell_sum;
			results_due.push_back(e);
		endfunction

		// Prints one mismatch line, up to a cap, and counts it.
		task report(string msg);
			if (errors < PRINT_CAP)
				$display("%0t ns: %s", $realtime, msg);
			errors++;
		endtask

		task compare(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got %0h, expected %0h",
					results_seen, name, got, want));
		endtask

		// Compares an accepted result transaction with the oldest prediction.
		task check_result(res_t got);
			res_t want;
			results_seen++;
			if (results_due.size() == 0) begin
				report($sformatf("result %0d arrived with nothing outstanding", results_seen));
				return;
			end
			want = results_due.pop_front();
			compare("wrapped_z", got.wrapped_z, want.wrapped_z);
			compare("zone", got.zone, want.zone);
			compare("event_res", got.event_res, want.event_res);
			compare("direction", got.direction, want.direction);
			compare("dwell_frames", got.dwell_frames, want.dwell_frames);
			compare("frame_index", got.frame_index, want.frame_index);
			compare("occupied_frames", got.occupied_frames, want.occupied_frames);
			compare("event_count", got.event_count, want.event_count);
			compare("dwell_total", got.dwell_total, want.dwell_total);
			compare("range_error", got.range_error, want.range_error);
		endtask
	endclass

	typedef struct {
		int z;
		int p;
		bit last;
	} coord_t;

	typedef struct {
		int unsigned len;
		int          lo;
		int          hi;
		bit          walk;
		int          items;
	} phase_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  push;
	logic                  full;
	logic signed [Z_W-1:0] z_pos;
	logic [PART_W-1:0]     particle;
	logic                  last_of_frame;
	logic                  empty;
	logic                  pop;
	logic signed [Z_W-1:0] wrapped_z;
	logic [1:0]            zone;
	logic                  event_res;
	logic                  direction;
	logic [CNT_W-1:0]      dwell_frames;
	logic [CNT_W-1:0]      frame_index;
	logic [CNT_W-1:0]      occupied_frames;
	logic [CNT_W-1:0]      event_count;
	logic [SUM_W-1:0]      dwell_total;
	logic                  range_error;

	transit_scoreboard board = new();
	res_t        observed;
	bit          steady = 1'b0;
	int          pop_hold = 0;
	int unsigned sends = 0;
	int unsigned cycle_count = 0;
	coord_t      directed[20];
	phase_t      phases[8];

	channel_translocation_tracker uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.z_pos(z_pos),
		.particle(particle),
		.last_of_frame(last_of_frame),
		.empty(empty),
		.pop(pop),
		.wrapped_z(wrapped_z),
		.zone(zone),
		.event_res(event_res),
		.direction(direction),
		.dwell_frames(dwell_frames),
		.frame_index(frame_index),
		.occupied_frames(occupied_frames),
		.event_count(event_count),
		.dwell_total(dwell_total),
		.range_error(range_error)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("channel_translocation_tracker_tb: errors");
			$finish;
		end
	end

	// Result side: pop with random stalls, some short and a few long.
	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold <= pop_hold - 1;
		end else if (steady || $urandom_range(0, 9) < 7) begin
			pop <= 1'b1;
		end else begin
			pop <= 1'b0;
			pop_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 0);
		end
	end

	// Every accepted coordinate transaction is handed to the predictor.
	always @(posedge clk) begin
		if (arst_n && push && !full)
			board.note_coordinate(z_pos, particle, last_of_frame);
	end

	// Every accepted result transaction is checked.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			observed.wrapped_z = wrapped_z;
			observed.zone = zone_t'(zone);
			observed.event_res = event_res;
			observed.direction = direction;
			observed.dwell_frames = dwell_frames;
			observed.frame_index = frame_index;
			observed.occupied_frames = occupied_frames;
			observed.event_count = event_count;
			observed.dwell_total = dwell_total;
			observed.range_error = range_error;
			board.check_result(observed);
		end
	end

	function automatic int random_coord();
		logic signed [Z_W-1:0] v;
		v = Z_W'($urandom);
		return int'(v);
	endfunction

	// Picks a coordinate whose wrapped value lies in the given zone, sometimes
	// shifted by whole box lengths so that the wrap and the range check are hit.
	function automatic int coord_in_zone(zone_t zn, int unsigned len, int lo, int hi);
		longint w, z;
		int pick, k;
		case (zn)
			ZONE_BELOW: w = longint'($urandom_range(lo - 1, 0));
			ZONE_ABOVE: w = longint'($urandom_range(len - 1, hi + 1));
			default: begin
				pick = $urandom_range(0, 7);
				w = longint'((pick == 0) ? lo : (pick == 1) ? hi : $urandom_range(hi, lo));
			end
		endcase
		pick = $urandom_range(0, 19);
		k = (pick < 12) ? 0 : (pick < 15) ? -1 : (pick < 18) ? 1 : (pick == 18) ? -2 : 2;
		z = w + k * longint'(len);
		if (z < -8388608 || z > 8388607)
			z = w;
		return int'(z);
	endfunction

	// Presents one coordinate transaction after a random gap and waits until taken.
	task automatic send_coord(input int z, input int p, input bit last);
		int gap, roll;
		gap = 0;
		sends++;
		if (sends % 40 == 0)
			steady = ($urandom_range(0, 3) == 0);
		if (!steady) begin
			roll = $urandom_range(0, 99);
			if (roll >= 95)
				gap = $urandom_range(40, 10);
			else if (roll >= 60)
				gap = $urandom_range(3, 1);
		end
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		z_pos <= Z_W'(z);
		particle <= PART_W'(p);
		last_of_frame <= last;
		do @(posedge clk); while (full);
	endtask

	// Holds the input side until every predicted result has come back.
	task automatic drain_results();
		push <= 1'b0;
		do @(posedge clk); while (board.results_due.size() != 0);
	endtask

	// Writes all three registers once the block has gone idle.
	task automatic load_setup(input int unsigned len, input int lo, input int hi);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_BOX_LENGTH;
		cfg_wdata <= CFG_W'(len);
		board.set_register(CFG_BOX_LENGTH, CFG_W'(len));
		@(posedge clk);
		cfg_index <= CFG_LOWER_BOUND;
		cfg_wdata <= CFG_W'(lo);
		board.set_register(CFG_LOWER_BOUND, CFG_W'(lo));
		@(posedge clk);
		cfg_index <= CFG_UPPER_BOUND;
		cfg_wdata <= CFG_W'(hi);
		board.set_register(CFG_UPPER_BOUND, CFG_W'(hi));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Frames of a small particle group wandering between zones, with some noise,
	// broken frame boundaries and an occasional full pause.
	task automatic run_walk(input int items, input int unsigned len, input int lo, input int hi);
		zone_t pace[8];
		int base, nparts, sent, i, roll, z;
		bit last;
		base = $urandom_range(DEF_MAX_PARTICLES - 8, 0);
		nparts = $urandom_range(8, 2);
		foreach (pace[k])
			pace[k] = zone_t'($urandom_range(2, 0));
		sent = 0;
		while (sent < items) begin
			for (i = 0; i < nparts && sent < items; i++) begin
				roll = $urandom_range(0, 9);
				if (pace[i] == ZONE_INSIDE) begin
					if (roll < 3)
						pace[i] = ZONE_BELOW;
					else if (roll < 6)
						pace[i] = ZONE_ABOVE;
				end else if (roll < 5) begin
					pace[i] = ZONE_INSIDE;
				end
				z = coord_in_zone(pace[i], len, lo, hi);
				last = (i == nparts - 1);
				roll = $urandom_range(0, 39);
				if (roll < 4)
					z = random_coord();
				else if (roll == 4)
					last = !last;
				else if (roll == 5)
					drain_results();
				send_coord(z, base + i, last);
				sent++;
			end
		end
	endtask

	task automatic run_noise(input int items);
		int n;
		for (n = 0; n < items; n++)
			send_coord(random_coord(), $urandom_range(DEF_MAX_PARTICLES - 1, 0),
				$urandom_range(0, 3) == 0);
	endtask

	// Main sequence: reset, directed frames, then randomized phases.
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_BOX_LENGTH;
		cfg_wdata <= '0;
		push <= 1'b0;
		z_pos <= '0;
		particle <= '0;
		last_of_frame <= 1'b0;

		// Frame zero covers field extremes, the box and range edges and the
		// channel edges; frames one and two walk two particles through the channel.
		directed = '{
			'{-8388608, 0, 1'b0}, '{8388607, 1023, 1'b0}, '{0, 1, 1'b0},
			'{-1, 2, 1'b0}, '{-655360, 3, 1'b0}, '{-655361, 4, 1'b0},
			'{1310719, 7, 1'b0}, '{1310720, 8, 1'b0}, '{131072, 9, 1'b0},
			'{393216, 10, 1'b0}, '{131071, 11, 1'b0}, '{393217, 12, 1'b0},
			'{1000, 5, 1'b0}, '{500000, 6, 1'b1},
			'{200000, 5, 1'b0}, '{300000, 6, 1'b0}, '{-355360, 9, 1'b1},
			'{600000, 5, 1'b0}, '{50000, 6, 1'b0}, '{393216, 9, 1'b1}
		};
		phases = '{
			'{655360, 131072, 393216, 1'b1, 130},
			'{1, 0, 0, 1'b0, 25},
			'{0, -8388608, 8388607, 1'b0, 25},
			'{8388607, 1000000, 7000000, 1'b1, 100},
			'{655360, 400000, 100000, 1'b0, 40},
			'{65536, -8388608, -8388608, 1'b0, 20},
			'{1000, 8388607, 8388607, 1'b0, 20},
			'{300000, 50000, 250000, 1'b1, 100}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_setup(655360, 131072, 393216);
		foreach (directed[i])
			send_coord(directed[i].z, directed[i].p, directed[i].last);

		foreach (phases[i]) begin
			load_setup(phases[i].len, phases[i].lo, phases[i].hi);
			if (phases[i].walk)
				run_walk(phases[i].items, phases[i].len, phases[i].lo, phases[i].hi);
			else
				run_noise(phases[i].items);
		end

		// Let the pipeline empty out, then a little longer for stray results.
		drain_results();
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("channel_translocation_tracker_tb: clean");
		else
			$display("channel_translocation_tracker_tb: errors");
		$finish;
	end

endmodule
